### rtl/tdmaut_pkg.sv
`default_nettype none
package tdmaut_pkg;

    localparam int TIME_W     = 58;
    localparam int SFD_W      = 32;
    localparam int TD_W       = 32;
    localparam int TCNT_W     = 6;
    localparam int MASK_W     = 32;
    localparam int UPS_W      = 6;
    localparam int NCNT_W     = 11;
    localparam int NODE_W     = 10;
    localparam int MAX_TILES  = 32;
    localparam int TIDX_W     = $clog2(MAX_TILES + 1);
    localparam int MIDX_W     = $clog2(MASK_W);
    localparam int TCMP_W     = (TIDX_W > TCNT_W) ? TIDX_W : TCNT_W;
    localparam int NODE_MIN   = 2;
    localparam int NODE_MAX   = 1024;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = $clog2(TIME_W);

    localparam logic [CFG_IDX_W-1:0] REG_SFD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TCNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UPS  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NCNT = 3'd5;

    typedef struct packed {
        logic [SFD_W-1:0]  superframe_duration;
        logic [TD_W-1:0]   tile_duration;
        logic [TCNT_W-1:0] tile_count;
        logic [MASK_W-1:0] uplink_tile_mask;
        logic [UPS_W-1:0]  uplinks_per_superframe;
        logic [NCNT_W-1:0] node_count;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic mul_step;
        logic walk_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic walk_end;
    } sts_t;

endpackage
`default_nettype wire

### rtl/tdma_uplink_turn_from_time_top.sv
// Works out which node owns the next uplink turn of a round-robin TDMA schedule
// from a 58-bit network time.
// The input channel (in_valid, in_stall, network_time) takes one transaction at a
// time; in_stall is high while a time is being worked on.
// The output channel (out_valid, out_stall, next_node) delivers one transaction
// per input, held in an output register until the receiver takes it.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// register cfg_index; it is always ready and must only be used while idle.
// Each time passes in order through the bit-serial divider, a shift-add modular
// multiply and a walk over the elapsed tiles, of which there are 0 to 32.
// The divider yields one quotient bit per cycle, with the count reduced modulo
// node_count-1 on the fly, and the walk covers one tile per cycle.
// A new time is accepted the cycle after the result is registered, so the
// input takes no new time before the last one is through.
// If the receiver stalls, a finished result waits in the final state until the
// output register is free, and no new input is accepted while it waits; a new
// input is accepted while the output register holds an untaken result.
// Reset clears the controller and restores the register defaults.
`default_nettype none
module tdma_uplink_turn_from_time_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [tdmaut_pkg::TIME_W-1:0]       network_time,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic      [tdmaut_pkg::NODE_W-1:0]       next_node,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tdmaut_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tdmaut_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tdmaut_pkg::cfg_t cfg;
    tdmaut_pkg::cmd_t cmd;
    tdmaut_pkg::sts_t sts;

    tdmaut_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tdmaut_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    tdmaut_dp u_dp (
        .clk          (clk),
        .cfg          (cfg),
        .cmd          (cmd),
        .sts          (sts),
        .network_time (network_time),
        .next_node    (next_node)
    );

endmodule
`default_nettype wire

### rtl/tdmaut_cfg.sv
`default_nettype none
module tdmaut_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tdmaut_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tdmaut_pkg::CFG_DATA_W-1:0]   cfg_data,
    output tdmaut_pkg::cfg_t                         cfg
);

    tdmaut_pkg::cfg_t cfg_reg;
    tdmaut_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tdmaut_pkg::REG_SFD:
                    cfg_next.superframe_duration = cfg_data[tdmaut_pkg::SFD_W-1:0];
                tdmaut_pkg::REG_TD:
                    cfg_next.tile_duration = cfg_data[tdmaut_pkg::TD_W-1:0];
                tdmaut_pkg::REG_TCNT:
                    cfg_next.tile_count = cfg_data[tdmaut_pkg::TCNT_W-1:0];
                tdmaut_pkg::REG_MASK:
                    cfg_next.uplink_tile_mask = cfg_data[tdmaut_pkg::MASK_W-1:0];
                tdmaut_pkg::REG_UPS:
                    cfg_next.uplinks_per_superframe = cfg_data[tdmaut_pkg::UPS_W-1:0];
                tdmaut_pkg::REG_NCNT:
                    cfg_next.node_count = cfg_data[tdmaut_pkg::NCNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.superframe_duration    <= tdmaut_pkg::SFD_W'(1);
            cfg_reg.tile_duration          <= tdmaut_pkg::TD_W'(1);
            cfg_reg.tile_count             <= tdmaut_pkg::TCNT_W'(1);
            cfg_reg.uplink_tile_mask       <= '0;
            cfg_reg.uplinks_per_superframe <= '0;
            cfg_reg.node_count             <= tdmaut_pkg::NCNT_W'(tdmaut_pkg::NODE_MIN);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

### rtl/tdmaut_ctrl.sv
`default_nettype none
module tdmaut_ctrl (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  wire logic         out_stall,
    input  wire tdmaut_pkg::sts_t sts,
    output tdmaut_pkg::cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]                    state_reg;
    logic [2:0]                    state_next;
    logic [tdmaut_pkg::STEP_W-1:0] cnt_reg;
    logic [tdmaut_pkg::STEP_W-1:0] cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == tdmaut_pkg::STEP_W'(tdmaut_pkg::TIME_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == tdmaut_pkg::STEP_W'(tdmaut_pkg::UPS_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_WALK;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_WALK:
            begin
                if (sts.walk_end)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### rtl/tdmaut_dp.sv
`default_nettype none
module tdmaut_dp (
    input  wire logic                              clk,
    input  wire tdmaut_pkg::cfg_t                  cfg,
    input  wire tdmaut_pkg::cmd_t                  cmd,
    output tdmaut_pkg::sts_t                       sts,
    input  wire logic [tdmaut_pkg::TIME_W-1:0]     network_time,
    output logic      [tdmaut_pkg::NODE_W-1:0]     next_node
);

    localparam int SFD_W  = tdmaut_pkg::SFD_W;
    localparam int NODE_W = tdmaut_pkg::NODE_W;
    localparam int TCMP_W = tdmaut_pkg::TCMP_W;

    logic [tdmaut_pkg::TIME_W-1:0] t_reg;
    logic [tdmaut_pkg::TIME_W-1:0] t_next;
    logic [SFD_W-1:0]              rem_reg;
    logic [SFD_W-1:0]              rem_next;
    logic [NODE_W-1:0]             cm_reg;
    logic [NODE_W-1:0]             cm_next;
    logic [NODE_W-1:0]             phase_reg;
    logic [NODE_W-1:0]             phase_next;
    logic [tdmaut_pkg::UPS_W-1:0]  ups_reg;
    logic [tdmaut_pkg::UPS_W-1:0]  ups_next;
    logic [tdmaut_pkg::TIDX_W-1:0] idx_reg;
    logic [tdmaut_pkg::TIDX_W-1:0] idx_next;
    logic [NODE_W-1:0]             node_reg;
    logic [NODE_W-1:0]             node_next;

    logic [SFD_W-1:0]  sfd;
    logic [NODE_W-1:0] m;
    logic [SFD_W:0]    rem_sh;
    logic              qbit;
    logic [NODE_W:0]   cm_sh;
    logic [NODE_W:0]   dbl;
    logic [NODE_W-1:0] dbl_red;
    logic [NODE_W:0]   sum;
    logic [NODE_W-1:0] sum_red;
    logic [NODE_W:0]   inc;
    logic [NODE_W-1:0] inc_red;
    logic [TCMP_W-1:0] tiles;
    logic [TCMP_W-1:0] tc;
    logic              up_tile;

    always_comb
    begin
        sfd = (cfg.superframe_duration == '0) ? SFD_W'(1) : cfg.superframe_duration;
        if (cfg.node_count < tdmaut_pkg::NCNT_W'(tdmaut_pkg::NODE_MIN))
        begin
            m = NODE_W'(tdmaut_pkg::NODE_MIN - 1);
        end
        else if (cfg.node_count > tdmaut_pkg::NCNT_W'(tdmaut_pkg::NODE_MAX))
        begin
            m = NODE_W'(tdmaut_pkg::NODE_MAX - 1);
        end
        else
        begin
            m = NODE_W'(cfg.node_count - 1'b1);
        end

        rem_sh = {rem_reg, t_reg[tdmaut_pkg::TIME_W-1]};
        qbit   = (rem_sh >= {1'b0, sfd});

        cm_sh = {cm_reg, qbit};
        cm_next = (cm_sh >= {1'b0, m}) ? NODE_W'(cm_sh - {1'b0, m}) : cm_sh[NODE_W-1:0];

        dbl     = {phase_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? NODE_W'(dbl - {1'b0, m}) : dbl[NODE_W-1:0];
        sum     = {1'b0, dbl_red}
                + (ups_reg[tdmaut_pkg::UPS_W-1] ? {1'b0, cm_reg} : '0);
        sum_red = (sum >= {1'b0, m}) ? NODE_W'(sum - {1'b0, m}) : sum[NODE_W-1:0];

        inc     = {1'b0, phase_reg} + 1'b1;
        inc_red = (inc >= {1'b0, m}) ? '0 : inc[NODE_W-1:0];

        tc    = TCMP_W'(cfg.tile_count);
        tiles = (tc > TCMP_W'(tdmaut_pkg::MAX_TILES)) ? TCMP_W'(tdmaut_pkg::MAX_TILES) : tc;
        up_tile = (TCMP_W'(idx_reg) < TCMP_W'(tdmaut_pkg::MASK_W))
               && cfg.uplink_tile_mask[idx_reg[tdmaut_pkg::MIDX_W-1:0]];
        sts.walk_end = (TCMP_W'(idx_reg) >= tiles) || (rem_reg < cfg.tile_duration);

        t_next     = t_reg;
        rem_next   = rem_reg;
        phase_next = phase_reg;
        ups_next   = ups_reg;
        idx_next   = idx_reg;
        node_next  = node_reg;
        if (cmd.load)
        begin
            t_next     = network_time;
            rem_next   = '0;
            phase_next = '0;
            ups_next   = cfg.uplinks_per_superframe;
            idx_next   = '0;
        end
        if (cmd.div_step)
        begin
            t_next   = {t_reg[tdmaut_pkg::TIME_W-2:0], 1'b0};
            rem_next = qbit ? SFD_W'(rem_sh - {1'b0, sfd}) : rem_sh[SFD_W-1:0];
        end
        if (cmd.mul_step)
        begin
            phase_next = sum_red;
            ups_next   = {ups_reg[tdmaut_pkg::UPS_W-2:0], 1'b0};
        end
        if (cmd.walk_step)
        begin
            rem_next = rem_reg - cfg.tile_duration;
            idx_next = idx_reg + 1'b1;
            if (up_tile)
            begin
                phase_next = inc_red;
            end
        end
        if (cmd.out_load)
        begin
            node_next = m - phase_reg;
        end
    end

    assign next_node = node_reg;

    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        rem_reg   <= rem_next;
        cm_reg    <= cmd.load ? '0 : (cmd.div_step ? cm_next : cm_reg);
        phase_reg <= phase_next;
        ups_reg   <= ups_next;
        idx_reg   <= idx_next;
        node_reg  <= node_next;
    end

endmodule
`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps

class turn_scoreboard;
    logic [tdmaut_pkg::NODE_W-1:0] pending[$];
    int errors;

    function new();
        errors = 0;
    endfunction

    function void note_input(logic [tdmaut_pkg::NODE_W-1:0] expected_node);
        pending.push_back(expected_node);
    endfunction

    function void check_result(logic [tdmaut_pkg::NODE_W-1:0] got);
        logic [tdmaut_pkg::NODE_W-1:0] expected_node;
        if (pending.size() == 0)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("ERROR: next_node %0d arrived with no transaction pending", got);
            end
        end
        else
        begin
            expected_node = pending.pop_front();
            if (got !== expected_node)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("ERROR: next_node expected %0d, got %0d", expected_node, got);
                end
            end
        end
    endfunction
endclass

module tb_top;
    import tdmaut_pkg::*;

    localparam bit [63:0] TIME_MAX = (64'd1 << TIME_W) - 64'd1;
    localparam int ITEMS_TOTAL = 1400;
    localparam int CYCLE_LIMIT = 1000000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic [TIME_W-1:0]     network_time;
    logic                  out_valid;
    logic                  out_stall;
    logic [NODE_W-1:0]     next_node;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    turn_scoreboard sb;
    cfg_t           model_cfg;
    int             items_sent;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             cycle_count;

    tdma_uplink_turn_from_time_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .network_time (network_time),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .next_node    (next_node),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [NODE_W-1:0] uplink_owner(cfg_t c, logic [TIME_W-1:0] t);
        bit [63:0] sfd;
        bit [63:0] nodes;
        bit [63:0] m;
        bit [63:0] sf_count;
        bit [63:0] offset;
        bit [63:0] phase;
        bit [63:0] td;
        bit [63:0] result;
        int        tiles;
        bit        walking;
        sfd = 64'(c.superframe_duration);
        if (sfd == 0)
        begin
            sfd = 64'd1;
        end
        nodes = 64'(c.node_count);
        if (nodes < 64'(NODE_MIN))
        begin
            nodes = 64'(NODE_MIN);
        end
        if (nodes > 64'(NODE_MAX))
        begin
            nodes = 64'(NODE_MAX);
        end
        m = nodes - 64'd1;
        sf_count = 64'(t) / sfd;
        offset = 64'(t) % sfd;
        phase = ((sf_count % m) * (64'(c.uplinks_per_superframe) % m)) % m;
        tiles = (c.tile_count > MAX_TILES) ? MAX_TILES : int'(c.tile_count);
        td = 64'(c.tile_duration);
        walking = 1'b1;
        for (int i = 0; i < tiles; i++)
        begin
            if (walking && offset < td)
            begin
                walking = 1'b0;
            end
            if (walking)
            begin
                offset = offset - td;
                if (i < MASK_W && c.uplink_tile_mask[i])
                begin
                    phase = (phase + 64'd1) % m;
                end
            end
        end
        result = nodes - 64'd1 - phase;
        return result[NODE_W-1:0];
    endfunction

    function automatic cfg_t make_cfg(bit [31:0] sfd, bit [31:0] td, bit [5:0] tc,
                                      bit [31:0] mask, bit [5:0] ups, bit [10:0] nc);
        cfg_t c;
        c.superframe_duration = sfd;
        c.tile_duration = td;
        c.tile_count = tc;
        c.uplink_tile_mask = mask;
        c.uplinks_per_superframe = ups;
        c.node_count = nc;
        return c;
    endfunction

    function automatic cfg_t random_cfg();
        cfg_t      c;
        bit [63:0] td;
        bit [63:0] sfd;
        int        tc;
        if ($urandom_range(0, 3) == 0)
        begin
            td = 64'($urandom);
        end
        else
        begin
            td = 64'($urandom_range(1, 64));
        end
        if ($urandom_range(0, 19) == 0)
        begin
            td = 64'd0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            tc = $urandom_range(0, 63);
        end
        else
        begin
            tc = $urandom_range(1, MAX_TILES);
        end
        if ($urandom_range(0, 3) == 0)
        begin
            sfd = 64'($urandom);
        end
        else
        begin
            sfd = 64'(tc) * td + 64'($urandom_range(0, 2 * int'(td[5:0]) + 1));
        end
        if ($urandom_range(0, 19) == 0)
        begin
            sfd = 64'd0;
        end
        c.superframe_duration = sfd[31:0];
        c.tile_duration = td[31:0];
        c.tile_count = tc[5:0];
        c.uplink_tile_mask = $urandom;
        if ($urandom_range(0, 4) == 0)
        begin
            c.uplinks_per_superframe = UPS_W'($urandom_range(0, 63));
        end
        else
        begin
            c.uplinks_per_superframe = UPS_W'($urandom_range(0, 32));
        end
        case ($urandom_range(0, 3))
            0: c.node_count = NCNT_W'($urandom_range(2, 12));
            1: c.node_count = NCNT_W'($urandom_range(0, 2047));
            2: c.node_count = NCNT_W'($urandom_range(13, NODE_MAX));
            default:
            begin
                case ($urandom_range(0, 6))
                    0: c.node_count = 11'd0;
                    1: c.node_count = 11'd1;
                    2: c.node_count = 11'd2;
                    3: c.node_count = 11'd3;
                    4: c.node_count = 11'd1024;
                    5: c.node_count = 11'd1025;
                    default: c.node_count = 11'd2047;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [TIME_W-1:0] pick_time(cfg_t c);
        bit [63:0] sfd;
        bit [63:0] td;
        bit [63:0] top;
        bit [63:0] sf_count;
        bit [63:0] w;
        bit [63:0] t;
        int        tiles;
        int        k;
        sfd = (c.superframe_duration == 0) ? 64'd1 : 64'(c.superframe_duration);
        td = 64'(c.tile_duration);
        tiles = (c.tile_count > MAX_TILES) ? MAX_TILES : int'(c.tile_count);
        top = TIME_MAX / sfd;
        case ($urandom_range(0, 9))
            0: t = {$urandom, $urandom};
            1: t = {$urandom, $urandom} >> $urandom_range(6, 63);
            default:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    sf_count = {$urandom, $urandom} % (top + 1);
                end
                else
                begin
                    sf_count = 64'($urandom_range(0, 1000)) % (top + 1);
                end
                k = $urandom_range(0, tiles + 1);
                case ($urandom_range(0, 3))
                    0: w = {$urandom, $urandom} % sfd;
                    1: w = 64'(k) * td;
                    2: w = 64'(k) * td - 1;
                    default: w = 64'(k) * td + {$urandom, $urandom} % ((td == 0) ? 64'd1 : td);
                endcase
                if (w >= sfd)
                begin
                    w = {$urandom, $urandom} % sfd;
                end
                t = sf_count * sfd + w;
                if (t > TIME_MAX)
                begin
                    t = TIME_MAX;
                end
            end
        endcase
        return t[TIME_W-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SFD:  model_cfg.superframe_duration = data[SFD_W-1:0];
            REG_TD:   model_cfg.tile_duration = data[TD_W-1:0];
            REG_TCNT: model_cfg.tile_count = data[TCNT_W-1:0];
            REG_MASK: model_cfg.uplink_tile_mask = data[MASK_W-1:0];
            REG_UPS:  model_cfg.uplinks_per_superframe = data[UPS_W-1:0];
            REG_NCNT: model_cfg.node_count = data[NCNT_W-1:0];
            default:  ;
        endcase
    endtask

    task automatic apply_config(input cfg_t c);
        logic [31:0] junk;
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        junk = $urandom;
        write_reg(REG_SFD, c.superframe_duration);
        write_reg(REG_TD, c.tile_duration);
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_SPARE_LO, $urandom);
        end
        write_reg(REG_TCNT, {junk[31:TCNT_W], c.tile_count});
        write_reg(REG_MASK, c.uplink_tile_mask);
        write_reg(REG_UPS, {junk[31:UPS_W], c.uplinks_per_superframe});
        write_reg(REG_NCNT, {junk[31:NCNT_W], c.node_count});
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(REG_SPARE_HI, $urandom);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic send_time(input logic [TIME_W-1:0] t);
        if (items_sent < ITEMS_TOTAL / 3)
        begin
            send_idle_pct = 30;
            recv_stall_pct = 54;
        end
        else if (items_sent < 2 * ITEMS_TOTAL / 3)
        begin
            send_idle_pct = 54;
            recv_stall_pct = 30;
        end
        else
        begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
        end
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        network_time <= t;
        do @(posedge clk); while (in_stall);
        sb.note_input(uplink_owner(model_cfg, t));
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            sb.check_result(next_node);
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int burst;
        sb = new();
        items_sent = 0;
        send_idle_pct = 30;
        recv_stall_pct = 54;
        cycle_count = 0;
        model_cfg = make_cfg(32'd1, 32'd1, 6'd1, 32'd0, 6'd0, 11'd2);
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        network_time <= '0;
        out_stall <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_time('0);
        send_time(TIME_MAX[TIME_W-1:0]);
        send_time(58'd1);
        send_time(58'd2);

        apply_config(make_cfg(32'd0, 32'd0, 6'd63, 32'hFFFF_FFFF, 6'd63, 11'd0));
        send_time('0);
        send_time(TIME_MAX[TIME_W-1:0]);
        send_time(58'd12345);

        apply_config(make_cfg(32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd32, 32'hAAAA_AAAA, 6'd32, 11'd2047));
        send_time('0);
        send_time(58'hFFFF_FFFE);
        send_time(58'hFFFF_FFFF);
        send_time(TIME_MAX[TIME_W-1:0]);

        apply_config(make_cfg(32'd100, 32'd10, 6'd12, 32'h0000_0FFF, 6'd5, 11'd1));
        send_time(58'd99);
        send_time(58'd100);

        apply_config(make_cfg(32'd1000, 32'd25, 6'd40, 32'hFFFF_FFFF, 6'd7, 11'd1024));
        send_time(58'd999);
        send_time(58'd800);
        send_time(58'd799);
        send_time(58'd12345025);

        apply_config(make_cfg(32'd35, 32'd1, 6'd33, 32'h8000_0001, 6'd3, 11'd3));
        send_time(58'd34);
        send_time(58'd31);
        send_time(58'd32);
        send_time(TIME_MAX[TIME_W-1:0]);

        apply_config(make_cfg(32'd7, 32'd2, 6'd3, 32'h0000_0005, 6'd1, 11'd1025));
        send_time(58'd5);
        send_time(58'd6);
        send_time(58'd13);

        while (items_sent < ITEMS_TOTAL)
        begin
            apply_config(random_cfg());
            burst = $urandom_range(20, 80);
            for (int i = 0; i < burst && items_sent < ITEMS_TOTAL; i++)
            begin
                send_time(pick_time(model_cfg));
            end
        end

        apply_config(make_cfg(32'd1, 32'd1, 6'd1, 32'd0, 6'd0, 11'd2));
        send_time(TIME_MAX[TIME_W-1:0]);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (120) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

### tdma_uplink_turn_from_time_top.f
rtl/tdmaut_pkg.sv
rtl/tdmaut_cfg.sv
rtl/tdmaut_ctrl.sv
rtl/tdmaut_dp.sv
rtl/tdma_uplink_turn_from_time_top.sv
test/tb_top.sv
